>>> design/spq_pkg.sv
// ============================================================================
// spq_pkg - shared codes for the stable priority task queue
// Operation codes, status codes, controller states and cell control groups.
// ============================================================================
package spq_pkg;

    localparam int FUNC_BITS      = 3;
    localparam int STATUS_BITS    = 2;
    localparam int COUNT_OUT_BITS = 5;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_GET    = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISS     = 2'd1,
        STATUS_EXECUTED = 2'd2,
        STATUS_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // control broadcast from the controller to every cell
    typedef struct packed {
        logic probe;      // latch compare flags against the incoming word
        logic probe_pop;  // probe selects the head instead of an id match
        logic do_insert;  // open a gap at the insert point, write new entry
        logic do_remove;  // close the gap at the first hit
    } t_cell_ctl;

    // flags one cell hands to its neighbors
    typedef struct packed {
        logic ge;         // held entry has priority >= request
        logic hit_seen;   // a hit at this cell or any cell nearer the head
    } t_cell_flags;

endpackage

>>> design/spq_cell.sv
// ============================================================================
// spq_cell - one slot of the sorted entry chain
// Holds one entry, compares it to the request, shifts toward head or tail.
// ============================================================================
module spq_cell #(
    parameter int ID_BITS       = 32,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_valid,      // slot lies below the count
    input  logic                     i_head,       // slot zero
    // compare operands, taken straight from the input port on probe
    input  logic [ID_BITS-1:0]       i_cmp_id,
    input  logic [PRIORITY_BITS-1:0] i_cmp_priority,
    // entry written on insert
    input  logic [ID_BITS-1:0]       i_new_id,
    input  logic [PRIORITY_BITS-1:0] i_new_priority,
    input  logic [PAYLOAD_BITS-1:0]  i_new_payload,
    // neighbor toward the head
    input  spq_pkg::t_cell_flags     i_left_flags,
    input  logic [ID_BITS-1:0]       i_left_id,
    input  logic [PRIORITY_BITS-1:0] i_left_priority,
    input  logic [PAYLOAD_BITS-1:0]  i_left_payload,
    // neighbor toward the tail
    input  logic [ID_BITS-1:0]       i_right_id,
    input  logic [PRIORITY_BITS-1:0] i_right_priority,
    input  logic [PAYLOAD_BITS-1:0]  i_right_payload,
    output spq_pkg::t_cell_flags     o_flags,
    output logic                     o_take,       // first hit sits here
    output logic [ID_BITS-1:0]       o_id,
    output logic [PRIORITY_BITS-1:0] o_priority,
    output logic [PAYLOAD_BITS-1:0]  o_payload
);

    logic [ID_BITS-1:0]       r_id;
    logic [PRIORITY_BITS-1:0] r_priority;
    logic [PAYLOAD_BITS-1:0]  r_payload;
    logic                     r_ge;
    logic                     r_hit;

    logic [ID_BITS-1:0]       n_id;
    logic [PRIORITY_BITS-1:0] n_priority;
    logic [PAYLOAD_BITS-1:0]  n_payload;
    logic                     n_ge;
    logic                     n_hit;

    always_comb begin
        n_ge  = r_ge;
        n_hit = r_hit;
        if (i_ctl.probe) begin
            n_ge  = i_valid && (r_priority >= i_cmp_priority);
            n_hit = i_valid && (i_ctl.probe_pop ? i_head : (r_id == i_cmp_id));
        end
    end

    // entries with ge form a prefix, so the insert point is the first
    // cell without ge; everything from there on moves one slot to the tail
    always_comb begin
        n_id       = r_id;
        n_priority = r_priority;
        n_payload  = r_payload;
        if (i_ctl.do_insert) begin
            if (!i_left_flags.ge) begin
                n_id       = i_left_id;
                n_priority = i_left_priority;
                n_payload  = i_left_payload;
            end else if (!r_ge) begin
                n_id       = i_new_id;
                n_priority = i_new_priority;
                n_payload  = i_new_payload;
            end
        end else if (i_ctl.do_remove) begin
            if (i_left_flags.hit_seen || r_hit) begin
                n_id       = i_right_id;
                n_priority = i_right_priority;
                n_payload  = i_right_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_ge  <= n_ge;
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_priority <= n_priority;
        r_payload  <= n_payload;
    end

    assign o_flags.ge       = r_ge;
    assign o_flags.hit_seen = i_left_flags.hit_seen || r_hit;
    assign o_take           = r_hit && !i_left_flags.hit_seen;
    assign o_id             = r_id;
    assign o_priority       = r_priority;
    assign o_payload        = r_payload;

endmodule

>>> design/stable_priority_task_queue_core.sv
// ============================================================================
// stable_priority_task_queue_core - sorted task queue built as a cell chain
// Descending priority, stable among equals; insert, pop, remove, get, clear.
// ============================================================================
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  request  | i_valid / o_stall  | func, task_id, priority_req, payload,
//           |                    | already_executed
//  result   | o_valid / i_stall  | status, out_id, out_priority, out_payload,
//           |                    | entry_count
//
//  Each request word is handled thus: the accept edge latches it and lets
//  every cell compare itself against it; the next edge shifts the chain and
//  loads the result register. No new word is taken while the chain shifts.
//  The result register parts the two sides: a request is taken while the
//  last result still waits, unless the result side is stalling.
//  Synchronous active-low reset empties the queue (count to zero).
// ============================================================================
module stable_priority_task_queue_core #(
    parameter int CAPACITY      = 16,
    parameter int ID_BITS       = 32,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [spq_pkg::FUNC_BITS-1:0]      i_func,
    input  logic [ID_BITS-1:0]                 i_task_id,
    input  logic [PRIORITY_BITS-1:0]           i_priority_req,
    input  logic [PAYLOAD_BITS-1:0]            i_payload,
    input  logic                               i_already_executed,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [spq_pkg::STATUS_BITS-1:0]    o_status,
    output logic [ID_BITS-1:0]                 o_out_id,
    output logic [PRIORITY_BITS-1:0]           o_out_priority,
    output logic [PAYLOAD_BITS-1:0]            o_out_payload,
    output logic [spq_pkg::COUNT_OUT_BITS-1:0] o_entry_count
);

    localparam int CntBits    = $clog2(CAPACITY + 1);
    localparam int CntOutBits = spq_pkg::COUNT_OUT_BITS;

    // ---- controller state --------------------------------------------------
    spq_pkg::t_state                  r_state;
    spq_pkg::t_state                  n_state;
    logic [CntBits-1:0]               r_count;
    logic [CntBits-1:0]               n_count;

    // latched request word
    logic [spq_pkg::FUNC_BITS-1:0]    r_func;
    logic [ID_BITS-1:0]               r_id;
    logic [PRIORITY_BITS-1:0]         r_priority;
    logic [PAYLOAD_BITS-1:0]          r_payload;
    logic                             r_executed;

    // result register
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [spq_pkg::STATUS_BITS-1:0]  r_status;
    logic [spq_pkg::STATUS_BITS-1:0]  n_status;
    logic [ID_BITS-1:0]               r_out_id;
    logic [ID_BITS-1:0]               n_out_id;
    logic [PRIORITY_BITS-1:0]         r_out_priority;
    logic [PRIORITY_BITS-1:0]         n_out_priority;
    logic [PAYLOAD_BITS-1:0]          r_out_payload;
    logic [PAYLOAD_BITS-1:0]          n_out_payload;
    logic [CntOutBits-1:0]            r_entry_count;
    logic [CntOutBits-1:0]            n_entry_count;

    logic                             w_accept;
    logic                             w_exec;
    logic                             w_any_hit;
    spq_pkg::t_cell_ctl               w_ctl;

    // ---- per-cell wiring ---------------------------------------------------
    logic                             w_valid    [CAPACITY];
    spq_pkg::t_cell_flags             w_flags    [CAPACITY];
    logic                             w_take     [CAPACITY];
    logic [ID_BITS-1:0]               w_id       [CAPACITY];
    logic [PRIORITY_BITS-1:0]         w_priority [CAPACITY];
    logic [PAYLOAD_BITS-1:0]          w_payload  [CAPACITY];

    assign w_accept = i_valid && !o_stall;
    assign w_exec   = (r_state == spq_pkg::ST_EXEC);

    // busy while the chain shifts; also hold off when the result is stuck
    assign o_stall  = w_exec || (r_out_valid && i_stall);

    // a slot is live when it lies below the count
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            w_valid[j] = (CntBits'(j) < r_count);
        end
    end

    // last cell's hit_seen covers the whole chain
    assign w_any_hit = w_flags[CAPACITY-1].hit_seen;

    // ---- cell control ------------------------------------------------------
    always_comb begin
        w_ctl.probe     = w_accept;
        w_ctl.probe_pop = (i_func == spq_pkg::FUNC_POP);
        w_ctl.do_insert = w_exec && (r_func == spq_pkg::FUNC_INSERT)
                          && !r_executed && (r_count != CntBits'(CAPACITY));
        w_ctl.do_remove = w_exec && w_any_hit
                          && ((r_func == spq_pkg::FUNC_POP)
                              || (r_func == spq_pkg::FUNC_REMOVE));
    end

    // ---- the chain ---------------------------------------------------------
    // cell 0 sees a virtual left neighbor that is ge and has no hit;
    // the tail cell refills from itself on removal (slot falls out of range)
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            spq_pkg::t_cell_flags     w_left_flags;
            logic [ID_BITS-1:0]       w_left_id;
            logic [PRIORITY_BITS-1:0] w_left_priority;
            logic [PAYLOAD_BITS-1:0]  w_left_payload;
            logic [ID_BITS-1:0]       w_right_id;
            logic [PRIORITY_BITS-1:0] w_right_priority;
            logic [PAYLOAD_BITS-1:0]  w_right_payload;

            if (k == 0) begin : g_head
                assign w_left_flags.ge       = 1'b1;
                assign w_left_flags.hit_seen = 1'b0;
                assign w_left_id             = r_id;
                assign w_left_priority       = r_priority;
                assign w_left_payload        = r_payload;
            end else begin : g_body
                assign w_left_flags    = w_flags[k-1];
                assign w_left_id       = w_id[k-1];
                assign w_left_priority = w_priority[k-1];
                assign w_left_payload  = w_payload[k-1];
            end

            if (k == CAPACITY - 1) begin : g_tail
                assign w_right_id       = w_id[k];
                assign w_right_priority = w_priority[k];
                assign w_right_payload  = w_payload[k];
            end else begin : g_inner
                assign w_right_id       = w_id[k+1];
                assign w_right_priority = w_priority[k+1];
                assign w_right_payload  = w_payload[k+1];
            end

            spq_cell #(
                .ID_BITS       (ID_BITS),
                .PRIORITY_BITS (PRIORITY_BITS),
                .PAYLOAD_BITS  (PAYLOAD_BITS)
            ) u_cell (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_ctl            (w_ctl),
                .i_valid          (w_valid[k]),
                .i_head           (k == 0),
                .i_cmp_id         (i_task_id),
                .i_cmp_priority   (i_priority_req),
                .i_new_id         (r_id),
                .i_new_priority   (r_priority),
                .i_new_payload    (r_payload),
                .i_left_flags     (w_left_flags),
                .i_left_id        (w_left_id),
                .i_left_priority  (w_left_priority),
                .i_left_payload   (w_left_payload),
                .i_right_id       (w_right_id),
                .i_right_priority (w_right_priority),
                .i_right_payload  (w_right_payload),
                .o_flags          (w_flags[k]),
                .o_take           (w_take[k]),
                .o_id             (w_id[k]),
                .o_priority       (w_priority[k]),
                .o_payload        (w_payload[k])
            );
        end
    endgenerate

    // ---- controller --------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC: begin
                n_state = spq_pkg::ST_IDLE;
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // result word and new count, resolved on the EXEC cycle
    always_comb begin
        n_count        = r_count;
        n_status       = r_status;
        n_out_id       = r_out_id;
        n_out_priority = r_out_priority;
        n_out_payload  = r_out_payload;
        n_out_valid    = r_out_valid && i_stall;

        if (w_exec) begin
            n_out_valid    = 1'b1;
            n_status       = spq_pkg::STATUS_OK;
            n_out_id       = '0;
            n_out_priority = '0;
            n_out_payload  = '0;
            case (r_func)
                spq_pkg::FUNC_INSERT: begin
                    // executed check goes ahead of the full check
                    if (r_executed) begin
                        n_status = spq_pkg::STATUS_EXECUTED;
                    end else if (r_count == CntBits'(CAPACITY)) begin
                        n_status = spq_pkg::STATUS_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                spq_pkg::FUNC_POP,
                spq_pkg::FUNC_REMOVE,
                spq_pkg::FUNC_GET: begin
                    if (w_any_hit) begin
                        // at most one cell holds take, so an OR picks it out
                        for (int j = 0; j < CAPACITY; j++) begin
                            if (w_take[j]) begin
                                n_out_id       = n_out_id | w_id[j];
                                n_out_priority = n_out_priority | w_priority[j];
                                n_out_payload  = n_out_payload | w_payload[j];
                            end
                        end
                        if (r_func != spq_pkg::FUNC_GET) begin
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        n_status = spq_pkg::STATUS_MISS;
                    end
                end
                spq_pkg::FUNC_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused codes leave the queue alone
                    n_count = r_count;
                end
            endcase
            n_entry_count = CntOutBits'(n_count);
        end else begin
            n_entry_count = r_entry_count;
        end
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= i_func;
            r_id       <= i_task_id;
            r_priority <= i_priority_req;
            r_payload  <= i_payload;
            r_executed <= i_already_executed;
        end
        r_status       <= n_status;
        r_out_id       <= n_out_id;
        r_out_priority <= n_out_priority;
        r_out_payload  <= n_out_payload;
        r_entry_count  <= n_entry_count;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_priority;
    assign o_out_payload  = r_out_payload;
    assign o_entry_count  = r_entry_count;

endmodule
